@@ hw/rtl/bccr_pkg.sv @@
// Package for the box collision classify and resolve block.
// Holds heading and side codes and the request/result structs; no dependencies.
`default_nettype none
package bccr_pkg;

    localparam logic [3:0] D_N  = 4'd0;
    localparam logic [3:0] D_NE = 4'd1;
    localparam logic [3:0] D_E  = 4'd2;
    localparam logic [3:0] D_SE = 4'd3;
    localparam logic [3:0] D_S  = 4'd4;
    localparam logic [3:0] D_SW = 4'd5;
    localparam logic [3:0] D_W  = 4'd6;
    localparam logic [3:0] D_NW = 4'd7;

    localparam logic [3:0] S_NONE = 4'd0;
    localparam logic [3:0] S_TL   = 4'd1;
    localparam logic [3:0] S_T    = 4'd2;
    localparam logic [3:0] S_TR   = 4'd3;
    localparam logic [3:0] S_L    = 4'd4;
    localparam logic [3:0] S_R    = 4'd5;
    localparam logic [3:0] S_BL   = 4'd6;
    localparam logic [3:0] S_B    = 4'd7;
    localparam logic [3:0] S_BR   = 4'd8;
    localparam logic [3:0] S_IN   = 4'd9;

    localparam int unsigned IN_BITS  = 151;
    localparam int unsigned IN_BYTES = 152;
    localparam int unsigned OUT_BITS = 45;
    localparam int unsigned OUT_BYTES = 48;

    typedef struct packed {
        logic [11:0]        other_height;
        logic [11:0]        other_width;
        logic signed [15:0] other_y;
        logic signed [15:0] other_x;
        logic [2:0]         response_flags;
        logic [3:0]         mover_direction;
        logic signed [15:0] mover_old_y;
        logic signed [15:0] mover_old_x;
        logic [11:0]        mover_height;
        logic [11:0]        mover_width;
        logic signed [15:0] mover_y;
        logic signed [15:0] mover_x;
    } t_request;

    typedef struct packed {
        logic               colliding;
        logic               stop_falling;
        logic [3:0]         new_direction;
        logic signed [16:0] shift_y;
        logic signed [16:0] shift_x;
        logic [3:0]         side_code;
        logic               hit;
    } t_result;

endpackage
`default_nettype wire

@@ hw/rtl/bccr_core.sv @@
// Combinational overlap test, side classification, push-out and redirect.
// Depends on bccr_pkg.
`default_nettype none
module bccr_core (
    input  var bccr_pkg::t_request i_req,
    output var bccr_pkg::t_result  o_res
);
    import bccr_pkg::*;

    logic signed [17:0] mx, my, mw, mh, mox, moy, ox, oy, ow, oh;
    logic signed [17:0] mxe, mye, oxe, oye, moxe, moye;
    logic [3:0] d;
    logic xc, yc, hit, rp, lb;
    logic [3:0] side, nd;
    logic up, lf, rt, dn;
    logic signed [17:0] sxv, syv;

    // Widened edges so no sum wraps.
    always_comb begin
        mx  = 18'(i_req.mover_x);
        my  = 18'(i_req.mover_y);
        mw  = {6'd0, i_req.mover_width};
        mh  = {6'd0, i_req.mover_height};
        mox = 18'(i_req.mover_old_x);
        moy = 18'(i_req.mover_old_y);
        ox  = 18'(i_req.other_x);
        oy  = 18'(i_req.other_y);
        ow  = {6'd0, i_req.other_width};
        oh  = {6'd0, i_req.other_height};
        d   = i_req.mover_direction;
        mxe  = mx + mw - 18'sd1;
        mye  = my + mh - 18'sd1;
        oxe  = ox + ow - 18'sd1;
        oye  = oy + oh - 18'sd1;
        moxe = mox + mw - 18'sd1;
        moye = moy + mh - 18'sd1;
        xc = (ox >= mx && ox <= mxe) || (mx >= ox && mx <= oxe) ||
             (moxe <= ox && mx > ox) || (mxe < oxe && mox >= oxe);
        yc = (oy >= my && oy <= mye) || (my >= oy && my <= oye) ||
             (moye <= oy && my > oy) || (mye < oye && moy >= oye);
        hit = (xc && yc) || i_req.response_flags[2];
        rp  = moxe > ox;
        lb  = mox < oxe;
    end

    // Side classification in priority order.
    always_comb begin
        if (mx < ox && my < oy && d != D_W && d != D_NW && d != D_N)
            side = S_TL;
        else if (my < oy && mx >= ox && mxe <= oxe && d != D_N && d != D_NW && d != D_NE)
            side = S_T;
        else if (mxe > oxe && my < oy && d != D_E && d != D_NE && d != D_N)
            side = S_TR;
        else if (mx < ox && my >= oy && mye <= oye && d != D_W && d != D_SW && d != D_NW)
            side = S_L;
        else if (mxe > oxe && my >= oy && mye <= oye && d != D_E && d != D_SE && d != D_NE)
            side = S_R;
        else if (mx < ox && mye > oye && d != D_W && d != D_SW && d != D_S)
            side = S_BL;
        else if (mye > oye && mx >= ox && mxe <= oxe && d != D_S && d != D_SW && d != D_SE)
            side = S_B;
        else if (mxe > oxe && mye > oye && d != D_E && d != D_SE && d != D_S)
            side = S_BR;
        else if (mx >= ox && my >= oy && mxe <= oxe && mye <= oye)
            side = S_IN;
        else if (moxe <= ox && mx >= ox)
            side = S_L;
        else if (mxe <= oxe && mox >= oxe)
            side = S_R;
        else if (moy <= oy && my >= oy)
            side = S_T;
        else if (my <= oy && moy >= oy)
            side = S_B;
        else
            side = S_NONE;
        if (!hit) side = S_NONE;
    end

    // Push-out direction.
    always_comb begin
        up = 1'b0; lf = 1'b0; rt = 1'b0; dn = 1'b0;
        case (side)
            S_TL: begin
                if (d == D_E || d == D_NE) rt = 1'b1;
                else if (d == D_S || d == D_SW) dn = 1'b1;
                else if (d == D_SE) begin dn = rp; rt = !rp; end
            end
            S_T: dn = 1'b1;
            S_TR: begin
                if (d == D_W || d == D_NW) lf = 1'b1;
                else if (d == D_S || d == D_SE) dn = 1'b1;
                else if (d == D_SW) begin dn = lb; lf = !lb; end
            end
            S_L: rt = 1'b1;
            S_R: lf = 1'b1;
            S_BL: begin
                if (d == D_E || d == D_SE) rt = 1'b1;
                else if (d == D_N || d == D_NW) up = 1'b1;
                else if (d == D_NE) begin up = rp; rt = !rp; end
            end
            S_B: up = 1'b1;
            S_BR: begin
                if (d == D_W || d == D_SW) lf = 1'b1;
                else if (d == D_N || d == D_NE) up = 1'b1;
                else if (d == D_NW) begin up = lb; lf = !lb; end
            end
            default: ;
        endcase
        sxv = rt ? ox - (mx + mw) : (lf ? (ox + ow) - mx : 18'sd0);
        syv = up ? (oy + oh) - my : (dn ? oy - (my + mh) : 18'sd0);
    end

    // Reflected heading.
    always_comb begin
        nd = d;
        case (side)
            S_T: begin
                if (d == D_S) nd = D_N;
                else if (d == D_SW) nd = D_NW;
                else if (d == D_SE) nd = D_NE;
            end
            S_R: begin
                if (d == D_W) nd = D_E;
                else if (d == D_NW) nd = D_NE;
                else if (d == D_SW) nd = D_SE;
            end
            S_B: begin
                if (d == D_N) nd = D_S;
                else if (d == D_NW) nd = D_SW;
                else if (d == D_NE) nd = D_SE;
            end
            S_L: begin
                if (d == D_E) nd = D_W;
                else if (d == D_NE) nd = D_NW;
                else if (d == D_SE) nd = D_SW;
            end
            S_TR: begin
                if (d == D_W) nd = D_E;
                else if (d == D_NW) nd = D_NE;
                else if (d == D_SW) nd = lb ? D_NW : D_SE;
                else if (d == D_S) nd = D_N;
                else if (d == D_SE) nd = D_NE;
            end
            S_TL: begin
                if (d == D_E) nd = D_W;
                else if (d == D_NE) nd = D_NW;
                else if (d == D_SE) nd = rp ? D_NE : D_SW;
                else if (d == D_S) nd = D_N;
                else if (d == D_SW) nd = D_NW;
            end
            S_BL: begin
                if (d == D_E) nd = D_W;
                else if (d == D_SE) nd = D_SW;
                else if (d == D_NE) nd = rp ? D_SE : D_NW;
                else if (d == D_N) nd = D_S;
                else if (d == D_NW) nd = D_SW;
            end
            S_BR: begin
                if (d == D_W) nd = D_E;
                else if (d == D_SW) nd = D_SE;
                else if (d == D_NW) nd = lb ? D_SW : D_NE;
                else if (d == D_N) nd = D_S;
                else if (d == D_NE) nd = D_SE;
            end
            default: ;
        endcase
    end

    // Pack the result; all but hit and side are gated by the flags.
    always_comb begin
        o_res.hit           = hit;
        o_res.side_code     = side;
        o_res.shift_x       = (hit && i_req.response_flags[0]) ? sxv[16:0] : 17'sd0;
        o_res.shift_y       = (hit && i_req.response_flags[0]) ? syv[16:0] : 17'sd0;
        o_res.stop_falling  = hit && i_req.response_flags[0] && dn;
        o_res.new_direction = (hit && i_req.response_flags[1]) ? nd : d;
        o_res.colliding     = hit && (i_req.response_flags[0] || i_req.response_flags[1]);
    end

endmodule
`default_nettype wire

@@ hw/rtl/box_collision_classify_resolve_top.sv @@
// Top level: input register, collision core and output register with stream ports.
// A request passes the input register, the core and the output register in order.
// Throughput: one request per cycle; the output register and the input register
// advance together whenever the output is empty or being taken.
// Reset: i_rst_n synchronous, active low, clears both valid flags only.
// Depends on bccr_pkg and bccr_core.
`default_nettype none
module box_collision_classify_resolve_top (
    input  var logic         i_clk,
    input  var logic         i_rst_n,
    input  var logic         s_axis_tvalid,
    output var logic         s_axis_tready,
    // Fields low to high: mover_x, mover_y, mover_width, mover_height, mover_old_x,
    // mover_old_y, mover_direction, response_flags, other_x, other_y,
    // other_width, other_height, one unused top bit.
    input  var logic [bccr_pkg::IN_BYTES-1:0] s_axis_tdata,
    output var logic         m_axis_tvalid,
    input  var logic         m_axis_tready,
    // Fields low to high: hit, side_code, shift_x, shift_y, new_direction,
    // stop_falling, colliding, zero fill.
    output var logic [bccr_pkg::OUT_BYTES-1:0] m_axis_tdata
);
    import bccr_pkg::*;

    logic     r_in_vld, r_out_vld, adv;
    t_request r_req;
    t_result  w_res, r_res;

    bccr_core u_core (.i_req(r_req), .o_res(w_res));

    // The pipe moves whenever the output slot is free or being drained.
    assign adv           = !r_out_vld || m_axis_tready;
    assign s_axis_tready = adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else if (adv) begin
            r_in_vld  <= s_axis_tvalid;
            r_out_vld <= r_in_vld;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_req <= s_axis_tdata[IN_BITS-1:0];
            r_res <= w_res;
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = {{(OUT_BYTES-OUT_BITS){1'b0}}, r_res};

    // A held result must not change while stalled.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld && !m_axis_tready |=> r_out_vld && $stable(r_res))
        else $error("result changed while stalled");
    // Ready follows the output slot.
    a_rdy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_out_vld |-> s_axis_tready)
        else $error("not ready with empty output");
    // An accepted request reaches the input stage.
    a_acc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> r_in_vld)
        else $error("accepted request lost");

endmodule
`default_nettype wire
